[rtl/window_level_pseudo_color_pixel_assert.svh]
// assertion macros for the window level pseudo color pixel block
// no dependencies
`ifndef WINDOW_LEVEL_PSEUDO_COLOR_PIXEL_ASSERT_SVH
`define WINDOW_LEVEL_PSEUDO_COLOR_PIXEL_ASSERT_SVH
`define WLPC_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("assertion failed");
`define WLPC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/wlpc_pkg.sv]
// shared types and constants for the window level pseudo color pixel block
// no dependencies
`default_nettype none
package wlpc_pkg;
  localparam int unsigned TdataInW = 24;
  localparam int unsigned TdataOutW = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned GammaEntries = 256;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_LOW   = 3'd0,
    REG_WINDOW_HIGH  = 3'd1,
    REG_BRIGHTNESS   = 3'd2,
    REG_CONTRAST     = 3'd3,
    REG_PSEUDO_COLOR = 3'd4,
    REG_INVERT       = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_TABLE = 1'b1
  } op_e;

  typedef struct packed {
    logic [15:0] window_low;
    logic [15:0] window_high;
    logic signed [8:0] brightness;
    logic [15:0] contrast_gain;
    logic pseudo_color;
    logic invert;
  } cfg_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_data;
  } tbl_wr_t;
endpackage
`default_nettype wire

[rtl/window_level_pseudo_color_pixel.sv]
// input transactions flow through the pipeline to the output, one pixel per cycle
// throughput one transaction per cycle, whole pipeline stalls while output valid and tready low
// window divide uses eight one-bit stages, gamma memory read is registered
// table writes enter the pipeline and land when they reach the memory stage
// asynchronous active low reset clears valid bits and resets configuration to its defaults
`default_nettype none
module window_level_pseudo_color_pixel (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata, // pixel_value, table_index, table_value
  input  wire logic        s_axis_tuser, // operation
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata, // red_out, green_out, blue_out
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import wlpc_pkg::*;

  localparam int unsigned Depth = 14;

  cfg_t cfg_q;
  logic en;
  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] tbl_q;
  logic [7:0] ti_q [13];
  logic [7:0] tv_q [13];
  logic [7:0] pr, pg, pb;
  logic [8:0] braw;
  tbl_wr_t wr;

  assign en = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;
  assign cfg_ready_o = 1'b1;
  assign braw = cfg_data_i[8:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_low <= 16'd0;
      cfg_q.window_high <= 16'd65280;
      cfg_q.brightness <= 9'sd0;
      cfg_q.contrast_gain <= 16'd1024;
      cfg_q.pseudo_color <= 1'b0;
      cfg_q.invert <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_LOW:   cfg_q.window_low <= cfg_data_i;
        REG_WINDOW_HIGH:  cfg_q.window_high <= cfg_data_i;
        REG_BRIGHTNESS:   cfg_q.brightness <= (braw == 9'h100) ? -9'sd255 : $signed(braw);
        REG_CONTRAST:     cfg_q.contrast_gain <= cfg_data_i;
        REG_PSEUDO_COLOR: cfg_q.pseudo_color <= cfg_data_i[0];
        REG_INVERT:       cfg_q.invert <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      tbl_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
      tbl_q <= {tbl_q[Depth-2:0], s_axis_tuser == OP_TABLE};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ti_q[0] <= s_axis_tdata[15:8];
      tv_q[0] <= s_axis_tdata[23:16];
      for (int i = 1; i < 13; i++) begin
        ti_q[i] <= ti_q[i-1];
        tv_q[i] <= tv_q[i-1];
      end
    end
  end

  wlpc_level_pipe u_pipe (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .pixel_i (s_axis_tdata[7:0]),
    .red_o   (pr),
    .green_o (pg),
    .blue_o  (pb)
  );

  // write in program order: table op at the same stage as the read
  assign wr.wr_en = en && vld_q[12] && tbl_q[12];
  assign wr.wr_addr = ti_q[12];
  assign wr.wr_data = tv_q[12];

  wlpc_gamma_mem u_mem (
    .clk_i    (clk_i),
    .en_i     (en),
    .wr_i     (wr),
    .addr_r_i (pr),
    .addr_g_i (pg),
    .addr_b_i (pb),
    .data_r_o (m_axis_tdata[7:0]),
    .data_g_o (m_axis_tdata[15:8]),
    .data_b_o (m_axis_tdata[23:16])
  );

  assign m_axis_tvalid = vld_q[13] && !tbl_q[13];
endmodule
`default_nettype wire

[rtl/wlpc_gamma_mem.sv]
// gamma table memory, one write port and three registered read ports
// depends on wlpc_pkg
`default_nettype none
module wlpc_gamma_mem (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire wlpc_pkg::tbl_wr_t wr_i,
  input  wire logic [7:0]        addr_r_i,
  input  wire logic [7:0]        addr_g_i,
  input  wire logic [7:0]        addr_b_i,
  output logic [7:0]             data_r_o,
  output logic [7:0]             data_g_o,
  output logic [7:0]             data_b_o
);
  import wlpc_pkg::*;

  logic [7:0] mem_r [GammaEntries];
  logic [7:0] mem_g [GammaEntries];
  logic [7:0] mem_b [GammaEntries];

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mem_r[wr_i.wr_addr] <= wr_i.wr_data;
      mem_g[wr_i.wr_addr] <= wr_i.wr_data;
      mem_b[wr_i.wr_addr] <= wr_i.wr_data;
    end
    if (en_i) begin
      data_r_o <= mem_r[addr_r_i];
      data_g_o <= mem_g[addr_g_i];
      data_b_o <= mem_b[addr_b_i];
    end
  end
endmodule
`default_nettype wire

[rtl/wlpc_level_pipe.sv]
// window stretch, contrast curve, invert and jet map pipeline
// depends on wlpc_pkg
`default_nettype none
module wlpc_level_pipe (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire wlpc_pkg::cfg_t cfg_i,
  input  wire logic [7:0]     pixel_i,
  output logic [7:0]          red_o,
  output logic [7:0]          green_o,
  output logic [7:0]          blue_o
);
  import wlpc_pkg::*;

  // stage 1: window compare and numerator
  logic [1:0]  s1_sel_q, s1_sel_d;
  logic [23:0] s1_num_q, s1_num_d;
  logic [15:0] s1_span_q, s1_span_d;
  // stage 2..9: restoring divider, one quotient bit per stage
  logic [23:0] dv_rem_q [1:7];
  logic [15:0] dv_span_q [1:7];
  logic [7:0]  dv_quo_q [1:8];
  logic [1:0]  dv_sel_q [1:8];
  // curve stages
  logic [7:0]  x_q;
  logic signed [35:0] n_q;
  logic [7:0]  lvl_q;
  logic [7:0]  r_q, g_q, b_q;

  logic [15:0] v;
  logic [15:0] diff;
  always_comb begin
    v = {pixel_i, 8'd0};
    diff = v - cfg_i.window_low;
    s1_span_d = cfg_i.window_high - cfg_i.window_low;
    s1_num_d = {diff, 8'd0} - {8'd0, diff};
    if (v < cfg_i.window_low) s1_sel_d = 2'd0;
    else if (v > cfg_i.window_high) s1_sel_d = 2'd1;
    else if (s1_span_d == 16'd0) s1_sel_d = 2'd0;
    else s1_sel_d = 2'd2;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_sel_q <= s1_sel_d;
      s1_num_q <= s1_num_d;
      s1_span_q <= s1_span_d;
    end
  end

  // quotient fits in 8 bits since numerator <= 255*span
  logic [23:0] rem_in [8];
  logic [15:0] span_in [8];
  logic [7:0]  quo_in [8];
  logic [1:0]  sel_in [8];
  logic [24:0] trial [8];
  always_comb begin
    rem_in[0] = s1_num_q;
    span_in[0] = s1_span_q;
    quo_in[0] = 8'd0;
    sel_in[0] = s1_sel_q;
    for (int i = 1; i < 8; i++) begin
      rem_in[i] = dv_rem_q[i];
      span_in[i] = dv_span_q[i];
      quo_in[i] = dv_quo_q[i];
      sel_in[i] = dv_sel_q[i];
    end
    for (int i = 0; i < 8; i++) begin
      trial[i] = {1'b0, rem_in[i]} - ({9'd0, span_in[i]} << (7 - i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 7; i++) begin
        dv_rem_q[i+1]  <= trial[i][24] ? rem_in[i] : trial[i][23:0];
        dv_span_q[i+1] <= span_in[i];
      end
      for (int i = 0; i < 8; i++) begin
        dv_quo_q[i+1] <= {quo_in[i][6:0], ~trial[i][24]};
        dv_sel_q[i+1] <= sel_in[i];
      end
    end
  end

  logic [7:0] x_d;
  always_comb begin
    case (dv_sel_q[8])
      2'd0: x_d = 8'd0;
      2'd1: x_d = 8'd255;
      default: x_d = dv_quo_q[8];
    endcase
  end

  logic signed [10:0] t;
  logic signed [9:0]  c;
  logic signed [27:0] prod;
  logic signed [35:0] n_d;
  always_comb begin
    t = $signed({2'b0, x_q, 1'b0}) - 11'sd255 + 11'(cfg_i.brightness);
    c = 10'sd255 + 10'(cfg_i.brightness);
    prod = t * $signed({1'b0, cfg_i.contrast_gain});
    n_d = 36'(prod) + (36'(c) <<< 10);
  end

  logic [7:0] lvl_d;
  always_comb begin
    if (n_q <= 0) lvl_d = 8'd0;
    else if (n_q[35:11] > 25'd255) lvl_d = 8'd255;
    else lvl_d = n_q[18:11];
    if (cfg_i.invert) lvl_d = 8'd255 - lvl_d;
  end

  logic [9:0] l4;
  logic [7:0] r_d, g_d, b_d;
  always_comb begin
    l4 = {lvl_q, 2'b00};
    r_d = lvl_q; g_d = lvl_q; b_d = lvl_q;
    if (cfg_i.pseudo_color) begin
      if (lvl_q < 8'd63) begin
        r_d = 8'd0; g_d = 8'(10'd254 - l4); b_d = 8'd255;
      end else if (lvl_q < 8'd127) begin
        r_d = 8'd0;
        g_d = (l4 < 10'd254) ? 8'd0 : 8'(l4 - 10'd254);
        b_d = (l4 > 10'd510) ? 8'd0
            : ((10'd510 - l4 > 10'd255) ? 8'd255 : 8'(10'd510 - l4));
      end else if (lvl_q < 8'd191) begin
        r_d = (l4 < 10'd510) ? 8'd0 : 8'(l4 - 10'd510);
        g_d = 8'd255; b_d = 8'd0;
      end else begin
        r_d = 8'd255;
        g_d = (l4 < 10'd767) ? 8'd255 : 8'(10'd1022 - l4);
        b_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      n_q <= n_d;
      lvl_q <= lvl_d;
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  assign red_o = r_q;
  assign green_o = g_q;
  assign blue_o = b_q;
endmodule
`default_nettype wire

[rtl/wlpc_checker.sv]
// port-level checker for the window level pseudo color pixel block
// depends on window_level_pseudo_color_pixel_assert.svh
`default_nettype none
`include "window_level_pseudo_color_pixel_assert.svh"
module wlpc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic cfg_ready_o
);
  `WLPC_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `WLPC_ASSERT_IMPL(a_ready, !m_axis_tvalid, s_axis_tready)
  `WLPC_ASSERT_IMPL(a_stall, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
  `WLPC_ASSERT_IMPL(a_cfg, 1'b1, cfg_ready_o)
endmodule

bind window_level_pseudo_color_pixel wlpc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata), .cfg_ready_o(cfg_ready_o)
);
`default_nettype wire
